[src/rttest_pkg.sv]
// Shared types and constants for the adaptive RTT estimator.
package rttest_pkg;

  localparam int unsigned TIME_WIDTH_DEF     = 32;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 16;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SRTT_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VAR_GAIN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADAPT_EN  = 2'd2;

  localparam logic REQ_RESTART = 1'b1;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_PREP = 7'b0000010,
    ST_CHK  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_MUL  = 7'b0010000,
    ST_SEL  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_e;

  typedef enum logic [5:0] {
    PH_ALPHA  = 6'b000001,
    PH_BETA   = 6'b000010,
    PH_SRTT   = 6'b000100,
    PH_ERR    = 6'b001000,
    PH_VSTART = 6'b010000,
    PH_VAR    = 6'b100000
  } phase_e;

endpackage

[src/rttest_intf.sv]
// Handshake channel interfaces for sample, result and configuration transactions.
interface rttest_in_if #(
  parameter int unsigned TW = rttest_pkg::TIME_WIDTH_DEF
);
  logic          valid;
  logic          ready;
  logic          req_type;
  logic [TW-1:0] rtt_sample_us;

  modport source (output valid, req_type, rtt_sample_us, input ready);
  modport sink   (input valid, req_type, rtt_sample_us, output ready);
endinterface

interface rttest_out_if #(
  parameter int unsigned TW = rttest_pkg::TIME_WIDTH_DEF,
  parameter int unsigned GF = rttest_pkg::GAIN_FRAC_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [TW-1:0] srtt_us;
  logic [TW-1:0] rttvar_us;
  logic [GF:0]   srtt_gain_used;
  logic [GF:0]   var_gain_used;
  logic          initialised;

  modport source (output valid, srtt_us, rttvar_us, srtt_gain_used, var_gain_used,
                  initialised, input ready);
  modport sink   (input valid, srtt_us, rttvar_us, srtt_gain_used, var_gain_used,
                  initialised, output ready);
endinterface

interface rttest_cfg_if #(
  parameter int unsigned GF = rttest_pkg::GAIN_FRAC_BITS_DEF
);
  logic                             valid;
  logic                             ready;
  logic [rttest_pkg::CFG_IDX_W-1:0] index;
  logic [GF:0]                      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/adaptive_rtt_estimator_core.sv]
// Adaptive Jacobson/Karels RTT estimator with bit-serial divider and multiplier.
// Restart or first sample goes straight to the output; fixed gains run the SRTT and RTTVAR
// multiplies; adaptive mode first divides and scales the gains, skipping the divide on saturation.
// Throughput: one transaction at a time; the next is taken once the result is in the
// output register. Set by the shared one-bit-per-cycle multiplier and the one-bit-per-cycle divider.
// Reset: asynchronous, active low; gains 0.125/0.25, adaptive mode on, estimator uninitialised.
module adaptive_rtt_estimator_core #(
  parameter int unsigned TIME_WIDTH     = rttest_pkg::TIME_WIDTH_DEF,
  parameter int unsigned GAIN_FRAC_BITS = rttest_pkg::GAIN_FRAC_BITS_DEF
) (
  input logic           clk_i,
  input logic           rst_ni,
  rttest_in_if.sink     smp_i,
  rttest_out_if.source  res_o,
  rttest_cfg_if.sink    cfg_i
);

  localparam int unsigned TW = TIME_WIDTH;
  localparam int unsigned GF = GAIN_FRAC_BITS;
  localparam int unsigned MW = (TW > GF + 2) ? TW : GF + 2;
  localparam int unsigned CW = $clog2(GF + 2);

  localparam logic [GF:0]   ONE_G = {1'b1, {GF{1'b0}}};
  localparam logic [MW-1:0] ONE_M = {{(MW-GF-1){1'b0}}, 1'b1, {GF{1'b0}}};
  localparam logic [CW-1:0] DIV_LAST = CW'(GF - 1);
  localparam logic [CW-1:0] MUL_LAST = CW'(GF);

  rttest_pkg::state_e st_q, st_d;
  rttest_pkg::phase_e ph_q, ph_d;

  logic [GF:0]   base_srtt_q, base_var_q;
  logic          adapt_q;
  logic [TW-1:0] srtt_q, srtt_d, var_q, var_d, prev_q, prev_d;
  logic          first_q, first_d;
  logic [TW-1:0] rtt_q, rtt_d, rem_q, rem_d, err_q, err_d;
  logic [GF:0]   alpha_q, alpha_d, beta_q, beta_d, k_q, k_d;
  logic          up_q, up_d;
  logic [MW-1:0] mul_hi_q, mul_hi_d, mul_d_q, mul_d_d;
  logic [GF:0]   mul_lo_q, mul_lo_d, mul_g_q, mul_g_d;
  logic [CW-1:0] cnt_q, cnt_d;

  logic          out_valid_q, out_valid_d;
  logic [TW-1:0] out_srtt_q, out_srtt_d, out_var_q, out_var_d;
  logic [GF:0]   out_alpha_q, out_alpha_d, out_beta_q, out_beta_d;
  logic          out_init_q, out_init_d;

  logic          in_fire;
  logic [GF:0]   a0, b0;
  logic [TW:0]   r2;
  logic          r2_ge;
  logic [MW:0]   mul_sum, mul_res;
  logic [TW-1:0] m_val, srtt_new, rtt_ad, err_ad;
  logic [TW-1:0] rtt_prev_ad;
  logic [GF:0]   kd_shift;

  assign smp_i.ready = (st_q == rttest_pkg::ST_IDLE);
  assign in_fire     = smp_i.valid && smp_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid          = out_valid_q;
  assign res_o.srtt_us        = out_srtt_q;
  assign res_o.rttvar_us      = out_var_q;
  assign res_o.srtt_gain_used = out_alpha_q;
  assign res_o.var_gain_used  = out_beta_q;
  assign res_o.initialised    = out_init_q;

  assign a0 = (base_srtt_q > ONE_G) ? ONE_G : base_srtt_q;
  assign b0 = (base_var_q > ONE_G) ? ONE_G : base_var_q;

  assign r2       = {rem_q, 1'b0};
  assign r2_ge    = (r2 >= {1'b0, prev_q});
  assign kd_shift = {k_q[GF-1:0], r2_ge};

  assign mul_sum = {1'b0, mul_hi_q} + (mul_g_q[0] ? {1'b0, mul_d_q} : '0);
  assign mul_res = {mul_hi_q, mul_lo_q[GF]};
  assign m_val   = mul_res[TW-1:0];

  assign srtt_new    = up_q ? srtt_q + m_val : srtt_q - m_val;
  assign rtt_ad      = (rtt_q >= srtt_q) ? rtt_q - srtt_q : srtt_q - rtt_q;
  assign err_ad      = (err_q >= var_q) ? err_q - var_q : var_q - err_q;
  assign rtt_prev_ad = (rtt_q >= prev_q) ? rtt_q - prev_q : prev_q - rtt_q;

  always_comb begin
    st_d     = st_q;
    ph_d     = ph_q;
    srtt_d   = srtt_q;
    var_d    = var_q;
    prev_d   = prev_q;
    first_d  = first_q;
    rtt_d    = rtt_q;
    rem_d    = rem_q;
    err_d    = err_q;
    alpha_d  = alpha_q;
    beta_d   = beta_q;
    k_d      = k_q;
    up_d     = up_q;
    mul_hi_d = mul_hi_q;
    mul_lo_d = mul_lo_q;
    mul_d_d  = mul_d_q;
    mul_g_d  = mul_g_q;
    cnt_d    = cnt_q;

    out_valid_d = out_valid_q;
    out_srtt_d  = out_srtt_q;
    out_var_d   = out_var_q;
    out_alpha_d = out_alpha_q;
    out_beta_d  = out_beta_q;
    out_init_d  = out_init_q;

    if (out_valid_q && res_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (st_q)
      rttest_pkg::ST_IDLE: begin
        if (in_fire) begin
          rtt_d = smp_i.rtt_sample_us;
          if (smp_i.req_type == rttest_pkg::REQ_RESTART) begin
            srtt_d  = '0;
            var_d   = '0;
            prev_d  = '0;
            first_d = 1'b1;
            alpha_d = '0;
            beta_d  = '0;
            st_d    = rttest_pkg::ST_DONE;
          end else if (first_q) begin
            srtt_d  = smp_i.rtt_sample_us;
            var_d   = smp_i.rtt_sample_us >> 1;
            prev_d  = smp_i.rtt_sample_us;
            first_d = 1'b0;
            alpha_d = '0;
            beta_d  = '0;
            st_d    = rttest_pkg::ST_DONE;
          end else begin
            alpha_d = a0;
            beta_d  = b0;
            st_d    = rttest_pkg::ST_PREP;
          end
        end
      end
      rttest_pkg::ST_PREP: begin
        if (adapt_q && (prev_q != '0)) begin
          rem_d = rtt_prev_ad;
          st_d  = rttest_pkg::ST_CHK;
        end else begin
          mul_d_d  = MW'(rtt_ad);
          mul_g_d  = alpha_q;
          up_d     = (rtt_q >= srtt_q);
          mul_hi_d = '0;
          mul_lo_d = '0;
          cnt_d    = '0;
          ph_d     = rttest_pkg::PH_SRTT;
          st_d     = rttest_pkg::ST_MUL;
        end
      end
      rttest_pkg::ST_CHK: begin
        cnt_d = '0;
        if (rem_q >= prev_q) begin
          k_d      = ONE_G;
          mul_d_d  = {ONE_M[MW-2:0], 1'b0};
          mul_g_d  = alpha_q;
          mul_hi_d = '0;
          mul_lo_d = '0;
          ph_d     = rttest_pkg::PH_ALPHA;
          st_d     = rttest_pkg::ST_MUL;
        end else begin
          k_d  = '0;
          st_d = rttest_pkg::ST_DIV;
        end
      end
      rttest_pkg::ST_DIV: begin
        rem_d = r2_ge ? TW'(r2 - {1'b0, prev_q}) : r2[TW-1:0];
        k_d   = kd_shift;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          mul_d_d  = ONE_M + {{(MW-GF-1){1'b0}}, kd_shift};
          mul_g_d  = alpha_q;
          mul_hi_d = '0;
          mul_lo_d = '0;
          cnt_d    = '0;
          ph_d     = rttest_pkg::PH_ALPHA;
          st_d     = rttest_pkg::ST_MUL;
        end
      end
      rttest_pkg::ST_MUL: begin
        mul_hi_d = mul_sum[MW:1];
        mul_lo_d = {mul_sum[0], mul_lo_q[GF:1]};
        mul_g_d  = mul_g_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == MUL_LAST) begin
          st_d = rttest_pkg::ST_SEL;
        end
      end
      rttest_pkg::ST_SEL: begin
        case (ph_q)
          rttest_pkg::PH_ALPHA: begin
            alpha_d  = (mul_res > {1'b0, ONE_M}) ? ONE_G : mul_res[GF:0];
            mul_d_d  = ONE_M - {{(MW-GF-1){1'b0}}, k_q};
            mul_g_d  = beta_q;
            mul_hi_d = '0;
            mul_lo_d = '0;
            cnt_d    = '0;
            ph_d     = rttest_pkg::PH_BETA;
            st_d     = rttest_pkg::ST_MUL;
          end
          rttest_pkg::PH_BETA: begin
            beta_d   = mul_res[GF:0];
            mul_d_d  = MW'(rtt_ad);
            mul_g_d  = alpha_q;
            up_d     = (rtt_q >= srtt_q);
            mul_hi_d = '0;
            mul_lo_d = '0;
            cnt_d    = '0;
            ph_d     = rttest_pkg::PH_SRTT;
            st_d     = rttest_pkg::ST_MUL;
          end
          rttest_pkg::PH_SRTT: begin
            srtt_d = srtt_new;
            ph_d   = rttest_pkg::PH_ERR;
          end
          rttest_pkg::PH_ERR: begin
            err_d = rtt_ad;
            ph_d  = rttest_pkg::PH_VSTART;
          end
          rttest_pkg::PH_VSTART: begin
            mul_d_d  = MW'(err_ad);
            mul_g_d  = beta_q;
            up_d     = (err_q >= var_q);
            mul_hi_d = '0;
            mul_lo_d = '0;
            cnt_d    = '0;
            ph_d     = rttest_pkg::PH_VAR;
            st_d     = rttest_pkg::ST_MUL;
          end
          rttest_pkg::PH_VAR: begin
            var_d  = up_q ? var_q + m_val : var_q - m_val;
            prev_d = rtt_q;
            st_d   = rttest_pkg::ST_DONE;
          end
          default: begin
            st_d = rttest_pkg::ST_IDLE;
          end
        endcase
      end
      rttest_pkg::ST_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_srtt_d  = srtt_q;
          out_var_d   = var_q;
          out_alpha_d = alpha_q;
          out_beta_d  = beta_q;
          out_init_d  = !first_q;
          st_d        = rttest_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = rttest_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= rttest_pkg::ST_IDLE;
      ph_q        <= rttest_pkg::PH_ALPHA;
      base_srtt_q <= ONE_G >> 3;
      base_var_q  <= ONE_G >> 2;
      adapt_q     <= 1'b1;
      srtt_q      <= '0;
      var_q       <= '0;
      prev_q      <= '0;
      first_q     <= 1'b1;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      srtt_q      <= srtt_d;
      var_q       <= var_d;
      prev_q      <= prev_d;
      first_q     <= first_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          rttest_pkg::CFG_SRTT_GAIN: base_srtt_q <= cfg_i.data;
          rttest_pkg::CFG_VAR_GAIN:  base_var_q  <= cfg_i.data;
          rttest_pkg::CFG_ADAPT_EN:  adapt_q     <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rtt_q       <= rtt_d;
    rem_q       <= rem_d;
    err_q       <= err_d;
    alpha_q     <= alpha_d;
    beta_q      <= beta_d;
    k_q         <= k_d;
    up_q        <= up_d;
    mul_hi_q    <= mul_hi_d;
    mul_lo_q    <= mul_lo_d;
    mul_d_q     <= mul_d_d;
    mul_g_q     <= mul_g_d;
    out_srtt_q  <= out_srtt_d;
    out_var_q   <= out_var_d;
    out_alpha_q <= out_alpha_d;
    out_beta_q  <= out_beta_d;
    out_init_q  <= out_init_d;
  end

endmodule

[src/rttest_chk.sv]
// Port-level checks for the RTT estimator, bound to the top level.
module rttest_chk #(
  parameter int unsigned TW = rttest_pkg::TIME_WIDTH_DEF,
  parameter int unsigned GF = rttest_pkg::GAIN_FRAC_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [TW-1:0] srtt_us,
  input logic [TW-1:0] rttvar_us,
  input logic [GF:0]   srtt_gain_used,
  input logic [GF:0]   var_gain_used,
  input logic          initialised,
  input logic          cfg_ready
);

  localparam logic [GF:0] ONE_G = {1'b1, {GF{1'b0}}};

  // one transaction in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(srtt_us) && $stable(rttvar_us)))
    else $error("stalled result changed");

  // only a restart yields an uninitialised result, and it is all zero
  a_restart_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !initialised) |->
      (srtt_us == '0 && rttvar_us == '0 && srtt_gain_used == '0 && var_gain_used == '0))
    else $error("restart result not cleared");

  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (srtt_gain_used <= ONE_G && var_gain_used <= ONE_G))
    else $error("gain above 1.0");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready)
    else $error("config port not ready");

endmodule

bind adaptive_rtt_estimator_core rttest_chk #(
  .TW(TIME_WIDTH),
  .GF(GAIN_FRAC_BITS)
) u_rttest_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (smp_i.valid),
  .in_ready       (smp_i.ready),
  .out_valid      (res_o.valid),
  .out_ready      (res_o.ready),
  .srtt_us        (res_o.srtt_us),
  .rttvar_us      (res_o.rttvar_us),
  .srtt_gain_used (res_o.srtt_gain_used),
  .var_gain_used  (res_o.var_gain_used),
  .initialised    (res_o.initialised),
  .cfg_ready      (cfg_i.ready)
);
